// ----- hw/rtl/sil_pkg.sv -----
// ---------------------------------------------------------------------------
// sil_pkg: shared types and constants
// Token format between front and back, lexer modes, character codes.
// ---------------------------------------------------------------------------
package sil_pkg;

    localparam int IDENT_MAX = 128;
    localparam int IDX_W     = $clog2(IDENT_MAX);
    localparam int LEN_W     = IDX_W + 1;
    localparam int CNT_W     = 21;
    localparam logic [CNT_W-1:0] TEXT_MAX = CNT_W'(1048576);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_STR     = 3'd1;
    localparam logic [2:0] MODE_STR_ESC = 3'd2;
    localparam logic [2:0] MODE_LINE    = 3'd3;
    localparam logic [2:0] MODE_BLOCK   = 3'd4;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] line;
        logic [CNT_W-1:0] col;
    } t_loc;

    typedef struct packed {
        logic       is_text;
        logic [7:0] data;
        logic       elig;
        logic       next_ok;
        logic       last;
        t_loc       loc;
    } t_tok;

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= TEXT_MAX) ? TEXT_MAX : v + CNT_W'(1);
    endfunction

endpackage

// ----- hw/rtl/sil_if.sv -----
// ---------------------------------------------------------------------------
// sil_if: item channels
// Input byte channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface sil_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, action, data_byte, last, input ready);
    modport sink   (input valid, action, data_byte, last, output ready);
endinterface

interface sil_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [20:0] position;
    logic [20:0] line_number;
    logic [20:0] column_number;
    modport source (output valid, found, position, line_number, column_number, input ready);
    modport sink   (input valid, found, position, line_number, column_number, output ready);
endinterface

// ----- hw/rtl/sql_identifier_locator_top.sv -----
// ---------------------------------------------------------------------------
// sql_identifier_locator_top: whole-word identifier search in SQL text
// Loads an identifier, scans text outside strings and comments, and reports
// the first whole-word match as position, line and column.
// ---------------------------------------------------------------------------
// One item is taken per cycle unless the input stalls; each text item leaves
// the front one item late because the lexer needs the following byte. After
// the last text item of a run the input is held off while the front emits the
// held byte. A result then passes the flush step, the token queue, the
// shift-and match stage with the registered read of the start-location ring,
// and the result register. Tokens still waiting in the queue or a stalled
// result channel delay it further, and the input stalls while the queue is
// full.
module sql_identifier_locator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sil_in_if.sink     i_item,
    sil_out_if.source  o_result
);
    import sil_pkg::*;

    t_tok tok_in, tok_out;
    logic push, full, pop, empty;

    sil_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_tok   (tok_in)
    );

    sil_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (tok_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_tok   (tok_out),
        .o_empty (empty)
    );

    sil_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (tok_out),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// ----- hw/rtl/sil_front.sv -----
// ---------------------------------------------------------------------------
// sil_front: lexer and position counters
// Accept items, classify text bytes one byte late, emit tokens.
// ---------------------------------------------------------------------------
module sil_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sil_in_if.sink          i_item,
    input  logic            i_full,
    output logic            o_push,
    output sil_pkg::t_tok   o_tok
);
    import sil_pkg::*;

    logic [2:0]       r_mode, n_mode;
    logic             r_skip, n_skip;
    logic             r_look_v, n_look_v;
    logic [7:0]       r_look_b, n_look_b;
    logic             r_look_pok, n_look_pok;
    t_loc             r_look_loc, n_look_loc;
    logic [CNT_W-1:0] r_bc, n_bc, r_line, n_line, r_col, n_col;
    logic             r_prev_cr, n_prev_cr;
    logic             r_flush, n_flush;

    logic             accept, nxv, cand;
    logic [2:0]       lx_mode;
    logic             lx_skip;

    assign i_item.ready = !r_flush && !i_full;
    assign accept = i_item.valid && i_item.ready;
    assign nxv = !r_flush;

    always_comb begin
        lx_mode = r_mode;
        lx_skip = 1'b0;
        cand    = 1'b0;
        if (r_skip) begin
            lx_skip = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_LINE: begin
                    if (r_look_b == CH_LF) lx_mode = MODE_NORMAL;
                end
                MODE_BLOCK: begin
                    if (r_look_b == CH_STAR && nxv && i_item.data_byte == CH_SLASH) begin
                        lx_mode = MODE_NORMAL;
                        lx_skip = 1'b1;
                    end
                end
                MODE_STR_ESC: lx_mode = MODE_STR;
                MODE_STR: begin
                    if (r_look_b == CH_BSL) lx_mode = MODE_STR_ESC;
                    else if (r_look_b == CH_QUOTE) lx_mode = MODE_NORMAL;
                end
                default: begin
                    if (r_look_b == CH_QUOTE) begin
                        lx_mode = MODE_STR;
                    end else if (r_look_b == CH_DASH && nxv && i_item.data_byte == CH_DASH) begin
                        lx_mode = MODE_LINE;
                        lx_skip = 1'b1;
                    end else if (r_look_b == CH_SLASH && nxv
                                 && i_item.data_byte == CH_STAR) begin
                        lx_mode = MODE_BLOCK;
                        lx_skip = 1'b1;
                    end else begin
                        cand = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_skip     = r_skip;
        n_look_v   = r_look_v;
        n_look_b   = r_look_b;
        n_look_pok = r_look_pok;
        n_look_loc = r_look_loc;
        n_bc       = r_bc;
        n_line     = r_line;
        n_col      = r_col;
        n_prev_cr  = r_prev_cr;
        n_flush    = r_flush;
        o_push     = 1'b0;
        o_tok      = '{is_text: 1'b1, data: r_look_b, elig: cand && r_look_pok,
                       next_ok: 1'b1, last: 1'b0, loc: r_look_loc};
        if (r_flush) begin
            if (!i_full) begin
                o_push   = 1'b1;
                o_tok.last = 1'b1;
                n_flush  = 1'b0;
                n_mode   = MODE_NORMAL;
                n_skip   = 1'b0;
                n_look_v = 1'b0;
                n_bc     = '0;
                n_line   = CNT_W'(1);
                n_col    = CNT_W'(1);
                n_prev_cr = 1'b0;
            end
        end else if (accept && !i_item.action) begin
            o_push       = 1'b1;
            o_tok.is_text = 1'b0;
            o_tok.data   = i_item.data_byte;
            o_tok.elig   = 1'b0;
            o_tok.last   = i_item.last;
            n_mode   = MODE_NORMAL;
            n_skip   = 1'b0;
            n_look_v = 1'b0;
            n_bc     = '0;
            n_line   = CNT_W'(1);
            n_col    = CNT_W'(1);
            n_prev_cr = 1'b0;
        end else if (accept) begin
            if (r_look_v) begin
                o_push        = 1'b1;
                o_tok.next_ok = !word_char(i_item.data_byte);
                n_mode        = lx_mode;
                n_skip        = lx_skip;
            end
            n_look_pok = (r_bc == '0) || !word_char(r_look_b);
            n_look_loc = '{pos: sat_inc(r_bc), line: r_line, col: r_col};
            n_look_b   = i_item.data_byte;
            n_look_v   = 1'b1;
            n_bc       = sat_inc(r_bc);
            if (i_item.data_byte == CH_CR) begin
                n_line = sat_inc(r_line);
                n_col  = CNT_W'(1);
            end else if (i_item.data_byte == CH_LF) begin
                if (!r_prev_cr) begin
                    n_line = sat_inc(r_line);
                    n_col  = CNT_W'(1);
                end
            end else begin
                n_col = sat_inc(r_col);
            end
            n_prev_cr = (i_item.data_byte == CH_CR);
            n_flush   = i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_skip    <= 1'b0;
            r_look_v  <= 1'b0;
            r_bc      <= '0;
            r_line    <= CNT_W'(1);
            r_col     <= CNT_W'(1);
            r_prev_cr <= 1'b0;
            r_flush   <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_skip    <= n_skip;
            r_look_v  <= n_look_v;
            r_bc      <= n_bc;
            r_line    <= n_line;
            r_col     <= n_col;
            r_prev_cr <= n_prev_cr;
            r_flush   <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_look_b   <= n_look_b;
        r_look_pok <= n_look_pok;
        r_look_loc <= n_look_loc;
    end

endmodule

// ----- hw/rtl/sil_queue.sv -----
// ---------------------------------------------------------------------------
// sil_queue: token queue
// Short first-in first-out buffer between front and back.
// ---------------------------------------------------------------------------
module sil_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sil_pkg::t_tok   i_tok,
    output logic            o_full,
    input  logic            i_pop,
    output sil_pkg::t_tok   o_tok,
    output logic            o_empty
);
    import sil_pkg::*;

    t_tok               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_tok   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + Q_PTR_W'(1);
            if (do_pop)  r_rp <= r_rp + Q_PTR_W'(1);
            r_cnt <= r_cnt + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_tok;
    end

endmodule

// ----- hw/rtl/sil_back.sv -----
// ---------------------------------------------------------------------------
// sil_back: identifier store and matcher
// Shift-and match over the token stream, start-location ring, result.
// ---------------------------------------------------------------------------
module sil_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sil_pkg::t_tok   i_tok,
    input  logic            i_empty,
    output logic            o_pop,
    sil_out_if.source       o_result
);
    import sil_pkg::*;

    logic [7:0]           r_ident [IDENT_MAX];
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_over, n_over, r_closed, n_closed;
    logic [IDENT_MAX-1:0] r_m, newm;
    logic [IDX_W-1:0]     r_idx, st;
    t_loc                 r_loc_mem [IDENT_MAX];
    t_loc                 r_rd_mem, r_byp_loc, r_res, rd;
    logic                 r_byp;
    logic                 r_b_v, r_b_hit, r_b_clr, r_b_final, r_found;
    logic                 r_out_v, n_found, blk, hit, is_final;
    logic [LEN_W-1:0]     base, lm1;

    assign is_final = i_tok.is_text && i_tok.last;
    assign o_pop = !i_empty && (!is_final ||
                   (!(r_b_v && r_b_final) && (!r_out_v || o_result.ready)));

    assign lm1 = r_len - LEN_W'(1);
    assign st  = r_idx - lm1[IDX_W-1:0];

    always_comb begin
        for (int k = 0; k < IDENT_MAX; k++) begin
            newm[k] = ((k == 0) ? i_tok.elig : r_m[(k == 0) ? 0 : k-1])
                      && (i_tok.data == r_ident[k]);
        end
    end

    assign blk = (r_found || (r_b_v && r_b_hit)) && !(r_b_v && r_b_clr);
    assign hit = o_pop && i_tok.is_text && r_len != '0 && !r_over &&
                 newm[lm1[IDX_W-1:0]] && i_tok.next_ok && !blk;

    assign base = r_closed ? '0 : r_len;
    always_comb begin
        n_len    = r_len;
        n_over   = r_over;
        n_closed = r_closed;
        if (o_pop && !i_tok.is_text) begin
            if (r_closed) n_over = 1'b0;
            if (base < LEN_W'(IDENT_MAX)) n_len = base + LEN_W'(1);
            else n_over = 1'b1;
            n_len    = (base < LEN_W'(IDENT_MAX)) ? base + LEN_W'(1) : base;
            n_closed = i_tok.last;
        end
    end

    assign rd      = r_byp ? r_byp_loc : r_rd_mem;
    assign n_found = r_found || r_b_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_over    <= 1'b0;
            r_closed  <= 1'b0;
            r_m       <= '0;
            r_idx     <= '0;
            r_b_v     <= 1'b0;
            r_b_hit   <= 1'b0;
            r_b_clr   <= 1'b0;
            r_b_final <= 1'b0;
            r_found   <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_over   <= n_over;
            r_closed <= n_closed;
            r_b_v     <= o_pop;
            r_b_hit   <= hit;
            r_b_clr   <= o_pop && (!i_tok.is_text || i_tok.last);
            r_b_final <= o_pop && is_final;
            if (o_pop) begin
                if (!i_tok.is_text || i_tok.last) begin
                    r_m   <= '0;
                    r_idx <= '0;
                end else begin
                    r_m   <= newm;
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (r_b_v) r_found <= r_b_clr ? 1'b0 : n_found;
            if (r_b_v && r_b_final) r_out_v <= 1'b1;
            else if (o_result.ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_tok.is_text && base < LEN_W'(IDENT_MAX)) begin
            r_ident[base[IDX_W-1:0]] <= i_tok.data;
        end
        if (o_pop && i_tok.is_text) r_loc_mem[r_idx] <= i_tok.loc;
        r_rd_mem  <= r_loc_mem[st];
        r_byp     <= (st == r_idx);
        r_byp_loc <= i_tok.loc;
        if (r_b_v && r_b_hit) r_res <= rd;
        if (r_b_v && r_b_final) begin
            o_result.found         <= n_found;
            o_result.position      <= !n_found ? '0 : (r_b_hit ? rd.pos  : r_res.pos);
            o_result.line_number   <= !n_found ? '0 : (r_b_hit ? rd.line : r_res.line);
            o_result.column_number <= !n_found ? '0 : (r_b_hit ? rd.col  : r_res.col);
        end
    end

    assign o_result.valid = r_out_v;

endmodule

// ----- hw/rtl/sil_checker.sv -----
// ---------------------------------------------------------------------------
// sil_checker: port-level checks
// Result consistency and handshake behavior seen at the top-level ports.
// ---------------------------------------------------------------------------
module sil_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_action,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [20:0] i_position,
    input logic [20:0] i_line_number,
    input logic [20:0] i_column_number
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_position))
        else $error("result dropped while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |->
            i_position == 21'd0 && i_line_number == 21'd0 && i_column_number == 21'd0)
        else $error("no match but nonzero location");

    a_found_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |->
            i_position != 21'd0 && i_line_number != 21'd0 && i_column_number != 21'd0)
        else $error("match with zero location");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action && i_in_last |=> !i_in_ready)
        else $error("input taken during text flush");

endmodule

bind sql_identifier_locator_top sil_checker u_sil_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_in_action     (i_item.action),
    .i_in_last       (i_item.last),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_found         (o_result.found),
    .i_position      (o_result.position),
    .i_line_number   (o_result.line_number),
    .i_column_number (o_result.column_number)
);
